[hw/rtl/dde_pkg.sv]
package dde_pkg;

	localparam int unsigned NumDigits = 5;
	localparam int unsigned DigitW    = 4;
	localparam int unsigned CursorW   = 3;
	localparam int unsigned ModeW     = 4;
	localparam int unsigned ButtonW   = 8;
	localparam int unsigned ValueW    = 17;

	// Bit positions within the button field.
	localparam int unsigned BtnUp    = 0;
	localparam int unsigned BtnDown  = 1;
	localparam int unsigned BtnLeft  = 2;
	localparam int unsigned BtnRight = 3;
	localparam int unsigned BtnSend  = 4;

	localparam logic OpButton   = 1'b0;
	localparam logic OpValidate = 1'b1;

	// Mode codes that change how the panel behaves.
	localparam logic [ModeW-1:0] ModeLim199  = 4'd0;
	localparam logic [ModeW-1:0] ModeOpen    = 4'd1;
	localparam logic [ModeW-1:0] ModeLim1999 = 4'd2;
	localparam logic [ModeW-1:0] ModeLim99   = 4'd3;
	localparam logic [ModeW-1:0] ModeBad7    = 4'd7;
	localparam logic [ModeW-1:0] ModeUnitsA  = 4'd8;
	localparam logic [ModeW-1:0] ModeUnitsB  = 4'd9;
	localparam logic [ModeW-1:0] ModeBad10   = 4'd10;
	localparam logic [ModeW-1:0] ModeBad11   = 4'd11;
	localparam logic [ModeW-1:0] ModeBad15   = 4'd15;

	localparam logic [CursorW-1:0] CursorLast = 3'd4;
	localparam logic [ModeW-1:0]   ModeReset  = ModeLim1999;

	typedef logic [DigitW-1:0] digit_t;
	// Element 0 is the ten-thousands digit, element 4 the units digit.
	typedef digit_t [NumDigits-1:0] digit_vec_t;

	typedef struct packed {
		digit_vec_t         digits;
		logic [CursorW-1:0] cursor;
		logic               sending;
	} panel_state_t;

	typedef struct packed {
		logic               op;
		logic [ButtonW-1:0] buttons;
		logic               write_check;
	} entry_item_t;

	// Limit digits are listed from units down to ten-thousands in the literals.
	localparam digit_vec_t Lim199Digits  = {4'd9, 4'd9, 4'd1, 4'd0, 4'd0};
	localparam digit_vec_t Lim1999Digits = {4'd9, 4'd9, 4'd9, 4'd1, 4'd0};
	localparam digit_vec_t Lim99Digits   = {4'd9, 4'd9, 4'd0, 4'd0, 4'd0};
	localparam digit_vec_t Lim1Digits    = {4'd1, 4'd0, 4'd0, 4'd0, 4'd0};
	localparam digit_vec_t Lim2047Digits = {4'd7, 4'd4, 4'd0, 4'd2, 4'd0};

	// Lowest digit index that the cursor may reach in a mode.
	function automatic logic [CursorW-1:0] span_low(input logic [ModeW-1:0] mode);
		logic [CursorW-1:0] low;
		unique case (mode) inside
			ModeLim199:             low = 3'd2;
			ModeOpen:               low = 3'd0;
			ModeLim99:              low = 3'd3;
			ModeUnitsA, ModeUnitsB: low = 3'd4;
			default:                low = 3'd1;
		endcase
		return low;
	endfunction

	function automatic logic mode_bad(input logic [ModeW-1:0] mode);
		logic bad;
		unique case (mode) inside
			ModeBad7, ModeBad10, ModeBad11, ModeBad15: bad = 1'b1;
			default:                                   bad = 1'b0;
		endcase
		return bad;
	endfunction

	function automatic logic [ValueW-1:0] limit_value(input logic [ModeW-1:0] mode);
		logic [ValueW-1:0] lim;
		unique case (mode) inside
			ModeLim199:             lim = 17'd199;
			ModeLim1999:            lim = 17'd1999;
			ModeLim99:              lim = 17'd99;
			ModeUnitsA, ModeUnitsB: lim = 17'd1;
			default:                lim = 17'd2047;
		endcase
		return lim;
	endfunction

	function automatic digit_vec_t limit_digits(input logic [ModeW-1:0] mode);
		digit_vec_t dv;
		unique case (mode) inside
			ModeLim199:             dv = Lim199Digits;
			ModeLim1999:            dv = Lim1999Digits;
			ModeLim99:              dv = Lim99Digits;
			ModeUnitsA, ModeUnitsB: dv = Lim1Digits;
			default:                dv = Lim2047Digits;
		endcase
		return dv;
	endfunction

endpackage

[hw/rtl/dde_update.sv]
module dde_update (
	input  logic [dde_pkg::ModeW-1:0] mode,
	input  dde_pkg::entry_item_t      item,
	input  dde_pkg::panel_state_t     cur,
	output dde_pkg::panel_state_t     nxt,
	output logic                      mode_ok
);

	logic [dde_pkg::CursorW-1:0] csel;
	logic [dde_pkg::CursorW-1:0] low;
	dde_pkg::digit_t             sel;
	logic [dde_pkg::ValueW-1:0]  value;
	logic                        one_button;

	assign csel = (cur.cursor <= dde_pkg::CursorLast) ? cur.cursor : dde_pkg::CursorLast;
	assign low  = dde_pkg::span_low(mode);
	assign sel  = cur.digits[csel];

	assign one_button = (item.buttons != 8'd0) &&
		((item.buttons & (item.buttons - 8'd1)) == 8'd0);

	assign value = 17'(cur.digits[0]) * 17'd10000 + 17'(cur.digits[1]) * 17'd1000 +
		17'(cur.digits[2]) * 17'd100 + 17'(cur.digits[3]) * 17'd10 +
		17'(cur.digits[4]);

	always_comb begin
		nxt     = cur;
		mode_ok = 1'b1;
		if (item.op == dde_pkg::OpButton) begin
			if (one_button) begin
				if (item.buttons[dde_pkg::BtnUp]) begin
					nxt.digits[csel] = (sel >= 4'd9) ? 4'd0 : sel + 4'd1;
				end else if (item.buttons[dde_pkg::BtnDown]) begin
					nxt.digits[csel] = (sel == 4'd0) ? 4'd9 : sel - 4'd1;
				end else if (item.buttons[dde_pkg::BtnLeft]) begin
					nxt.cursor = (csel <= low) ? dde_pkg::CursorLast : csel - 3'd1;
				end else if (item.buttons[dde_pkg::BtnRight]) begin
					nxt.cursor = (csel == dde_pkg::CursorLast) ? low : csel + 3'd1;
				end else if (item.buttons[dde_pkg::BtnSend]) begin
					nxt.sending = ~cur.sending;
				end
			end
		end else begin
			if (dde_pkg::mode_bad(mode)) begin
				mode_ok = 1'b0;
			end else if (item.write_check && (mode != dde_pkg::ModeOpen) &&
					(value > dde_pkg::limit_value(mode))) begin
				nxt.digits = dde_pkg::limit_digits(mode);
			end
		end
	end

endmodule

[hw/rtl/decimal_digit_entry_with_limit.sv]
// A result passes through stage 1 and then the result register before it is valid.
// Throughput: one transaction per cycle unless out_stall holds a result; the update is combinational.
// The rate is set by the loop from the panel state register through the update logic.
// Reset (arst_n low, asynchronous): mode 2, all digits 0, cursor at digit 4,
// sending cleared, both pipeline slots empty.
module decimal_digit_entry_with_limit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dde_pkg::ModeW-1:0]     digit_mode,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [dde_pkg::ButtonW-1:0]   buttons,
	input  logic                          write_check,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dde_pkg::DigitW-1:0]    digit_ten_thousands,
	output logic [dde_pkg::DigitW-1:0]    digit_thousands,
	output logic [dde_pkg::DigitW-1:0]    digit_hundreds,
	output logic [dde_pkg::DigitW-1:0]    digit_tens,
	output logic [dde_pkg::DigitW-1:0]    digit_units,
	output logic [dde_pkg::CursorW-1:0]   cursor_pos,
	output logic                          sending,
	output logic                          mode_ok
);

	// Stage 1 holds the accepted input transaction.
	logic                  valid_s1;
	dde_pkg::entry_item_t  item_s1;
	// Stage 2 is the result register that drives the output channel.
	logic                  valid_s2;
	dde_pkg::panel_state_t res_s2;
	logic                  ok_s2;

	// Architectural state of the panel.
	logic [dde_pkg::ModeW-1:0] mode_q;
	dde_pkg::panel_state_t     state_q;

	dde_pkg::panel_state_t state_nxt;
	logic                  ok_nxt;
	logic                  adv;
	logic                  in_take;
	logic                  cfg_take;

	// Always writable; writes must come only while the panel is idle, which the block does not check.
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;

	// Stage 1 moves into the result register whenever that register is empty
	// or its transaction is taken in this same cycle.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	dde_update u_update (
		.mode    (mode_q),
		.item    (item_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.mode_ok (ok_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op          <= op;
			item_s1.buttons     <= buttons;
			item_s1.write_check <= write_check;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= state_nxt;
			ok_s2  <= ok_nxt;
		end
	end

	// The panel state advances with each transaction that leaves stage 1, so the
	// next transaction in stage 1 already sees the updated digits and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.digits  <= '0;
			state_q.cursor  <= dde_pkg::CursorLast;
			state_q.sending <= 1'b0;
		end else begin
			if (adv) begin
				state_q.digits  <= state_nxt.digits;
				state_q.sending <= state_nxt.sending;
			end
			// A mode write homes the cursor on the units digit.
			if (cfg_take) begin
				state_q.cursor <= dde_pkg::CursorLast;
			end else if (adv) begin
				state_q.cursor <= state_nxt.cursor;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dde_pkg::ModeReset;
		end else if (cfg_take) begin
			mode_q <= digit_mode;
		end
	end

	assign out_valid           = valid_s2;
	assign digit_ten_thousands = res_s2.digits[0];
	assign digit_thousands     = res_s2.digits[1];
	assign digit_hundreds      = res_s2.digits[2];
	assign digit_tens          = res_s2.digits[3];
	assign digit_units         = res_s2.digits[4];
	assign cursor_pos          = res_s2.cursor;
	assign sending             = res_s2.sending;
	assign mode_ok             = ok_s2;

	// The cursor never leaves the five digit positions.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cursor <= dde_pkg::CursorLast)
		else $error("cursor outside digit range");

	// Every stored digit stays decimal.
	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.digits[0] > 4'd9 || state_q.digits[1] > 4'd9 ||
		  state_q.digits[2] > 4'd9 || state_q.digits[3] > 4'd9 ||
		  state_q.digits[4] > 4'd9))
		else $error("digit store holds a non-decimal value");

	// Input backpressure only comes from a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall && valid_s1))
		else $error("input stalled without a held result");

	// A transaction leaving stage 1 always shows up as a result next cycle.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced transaction lost");

	// A failed check is reported only for an invalid mode.
	a_mode_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ok_s2) |-> dde_pkg::mode_bad(mode_q))
		else $error("mode rejected while valid");

endmodule

[bench/tb_decimal_digit_entry_with_limit.sv]
`timescale 1ns / 1ps

module tb_decimal_digit_entry_with_limit;

	localparam int unsigned ModeCount = 16;

	// Button codes: no press, all bits set, and one-hot single presses.
	localparam logic [dde_pkg::ButtonW-1:0] PressNone  = 8'h00;
	localparam logic [dde_pkg::ButtonW-1:0] PressAll   = 8'hFF;
	localparam logic [dde_pkg::ButtonW-1:0] PressUp    = 8'd1 << dde_pkg::BtnUp;
	localparam logic [dde_pkg::ButtonW-1:0] PressDown  = 8'd1 << dde_pkg::BtnDown;
	localparam logic [dde_pkg::ButtonW-1:0] PressLeft  = 8'd1 << dde_pkg::BtnLeft;
	localparam logic [dde_pkg::ButtonW-1:0] PressRight = 8'd1 << dde_pkg::BtnRight;
	localparam logic [dde_pkg::ButtonW-1:0] PressSend  = 8'd1 << dde_pkg::BtnSend;

	localparam logic CheckRead  = 1'b0;
	localparam logic CheckWrite = 1'b1;

	localparam logic [dde_pkg::DigitW-1:0] DigitMax   = 4'd9;
	localparam int unsigned                IdleMax    = 13;
	localparam int unsigned                QuietLimit = 600;
	localparam int unsigned                ReportMax  = 10;

	// What the panel shows after one transaction. digits[0] is ten-thousands.
	typedef struct packed {
		dde_pkg::digit_vec_t         digits;
		logic [dde_pkg::CursorW-1:0] cursor;
		logic                        sending;
		logic                        ok;
	} panel_view_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [dde_pkg::ModeW-1:0]     digit_mode;
	logic                          in_valid;
	logic                          in_stall;
	logic                          op;
	logic [dde_pkg::ButtonW-1:0]   buttons;
	logic                          write_check;
	logic                          out_valid;
	logic                          out_stall;
	logic [dde_pkg::DigitW-1:0]    digit_ten_thousands;
	logic [dde_pkg::DigitW-1:0]    digit_thousands;
	logic [dde_pkg::DigitW-1:0]    digit_hundreds;
	logic [dde_pkg::DigitW-1:0]    digit_tens;
	logic [dde_pkg::DigitW-1:0]    digit_units;
	logic [dde_pkg::CursorW-1:0]   cursor_pos;
	logic                          sending;
	logic                          mode_ok;

	// Shadow copy of the panel, advanced whenever a transaction is accepted.
	logic [dde_pkg::ModeW-1:0]     pd_mode;
	dde_pkg::digit_vec_t           pd_digits;
	logic [dde_pkg::CursorW-1:0]   pd_cursor;
	logic                          pd_sending;

	panel_view_t pending_panels[$];
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	bit          no_idle      = 1'b0;
	// Intended levels of the two valids, so that a valid is never lowered and
	// raised again within one time step.
	bit          cfg_raised   = 1'b0;
	bit          item_raised  = 1'b0;

	decimal_digit_entry_with_limit i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.digit_mode          (digit_mode),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.op                  (op),
		.buttons             (buttons),
		.write_check         (write_check),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.digit_ten_thousands (digit_ten_thousands),
		.digit_thousands     (digit_thousands),
		.digit_hundreds      (digit_hundreds),
		.digit_tens          (digit_tens),
		.digit_units         (digit_units),
		.cursor_pos          (cursor_pos),
		.sending             (sending),
		.mode_ok             (mode_ok)
	);

	always #10 clk = ~clk;

	function automatic int unsigned ones_in(input logic [dde_pkg::ButtonW-1:0] b);
		int unsigned n;
		n = 0;
		for (int i = 0; i < dde_pkg::ButtonW; i++)
			if (b[i])
				n++;
		return n;
	endfunction

	// Applies one accepted transaction to the shadow panel and returns what
	// the block must show for it.
	task automatic advance_panel(input logic it_op, input logic [dde_pkg::ButtonW-1:0] it_btn,
			input logic it_wr, output panel_view_t view);
		logic [dde_pkg::CursorW-1:0] low;
		logic [dde_pkg::CursorW-1:0] sel;
		logic                        ok;
		logic                        bad;
		int unsigned                 total;
		int unsigned                 cap;
		ok = 1'b1;
		// The cursor may not go below this digit in the current mode.
		case (pd_mode) inside
			dde_pkg::ModeLim199:                      low = 3'd2;
			dde_pkg::ModeOpen:                        low = 3'd0;
			dde_pkg::ModeLim99:                       low = 3'd3;
			dde_pkg::ModeUnitsA, dde_pkg::ModeUnitsB: low = 3'd4;
			default:                                  low = 3'd1;
		endcase
		sel = (pd_cursor <= dde_pkg::CursorLast) ? pd_cursor : dde_pkg::CursorLast;
		bad = (pd_mode == dde_pkg::ModeBad7) || (pd_mode == dde_pkg::ModeBad10) ||
			(pd_mode == dde_pkg::ModeBad11) || (pd_mode == dde_pkg::ModeBad15);
		if (it_op == dde_pkg::OpButton) begin
			// A press counts only when exactly one bit is set; the spare
			// upper bits then simply do nothing.
			if (ones_in(it_btn) == 1) begin
				if (it_btn[dde_pkg::BtnUp]) begin
					pd_digits[sel] = (pd_digits[sel] >= DigitMax) ? '0 : pd_digits[sel] + 4'd1;
				end else if (it_btn[dde_pkg::BtnDown]) begin
					pd_digits[sel] = (pd_digits[sel] == '0) ? DigitMax : pd_digits[sel] - 4'd1;
				end else if (it_btn[dde_pkg::BtnLeft]) begin
					pd_cursor = (sel <= low) ? dde_pkg::CursorLast : sel - 3'd1;
				end else if (it_btn[dde_pkg::BtnRight]) begin
					pd_cursor = (sel == dde_pkg::CursorLast) ? low : sel + 3'd1;
				end else if (it_btn[dde_pkg::BtnSend]) begin
					pd_sending = ~pd_sending;
				end
			end
		end else if (bad) begin
			ok = 1'b0;
		end else if (it_wr == CheckWrite && pd_mode != dde_pkg::ModeOpen) begin
			case (pd_mode) inside
				dde_pkg::ModeLim199:                      cap = 199;
				dde_pkg::ModeLim1999:                     cap = 1999;
				dde_pkg::ModeLim99:                       cap = 99;
				dde_pkg::ModeUnitsA, dde_pkg::ModeUnitsB: cap = 1;
				default:                                  cap = 2047;
			endcase
			total = 0;
			for (int i = 0; i < dde_pkg::NumDigits; i++)
				total = total * 10 + 32'(pd_digits[i]);
			// Over the limit, the whole display is replaced by the limit itself.
			if (total > cap) begin
				for (int i = dde_pkg::NumDigits - 1; i >= 0; i--) begin
					pd_digits[i] = 4'(cap % 10);
					cap = cap / 10;
				end
			end
		end
		view.digits  = pd_digits;
		view.cursor  = pd_cursor;
		view.sending = pd_sending;
		view.ok      = ok;
	endtask

	task automatic release_cfg();
		if (cfg_raised) begin
			cfg_valid <= 1'b0;
			cfg_raised = 1'b0;
		end
	endtask

	// Sends one item after a random gap (none while no_idle is set) and records its
	// expected view once the block takes it.
	task automatic send_item(input logic it_op, input logic [dde_pkg::ButtonW-1:0] it_btn,
			input logic it_wr);
		int unsigned gap;
		panel_view_t view;
		gap = no_idle ? 0 : $urandom_range(IdleMax, 0);
		release_cfg();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		item_raised = 1'b1;
		op          <= it_op;
		buttons     <= it_btn;
		write_check <= it_wr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_panel(it_op, it_btn, it_wr, view);
		pending_panels.push_back(view);
	endtask

	// Stops sending and waits until every expected view has come out.
	task automatic settle_panel();
		if (item_raised) begin
			in_valid <= 1'b0;
			item_raised = 1'b0;
		end
		while (pending_panels.size() != 0)
			@(posedge clk);
	endtask

	// The mode is only rewritten while the panel is idle. A write also puts
	// the cursor back on the units digit.
	task automatic load_mode(input logic [dde_pkg::ModeW-1:0] m);
		settle_panel();
		digit_mode <= m;
		if (!cfg_raised)
			cfg_valid <= 1'b1;
		cfg_raised = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pd_mode   = m;
		pd_cursor = dde_pkg::CursorLast;
	endtask

	// Mostly single presses and checks, with some raw noise on all fields.
	task automatic draw_item(output logic it_op, output logic [dde_pkg::ButtonW-1:0] it_btn,
			output logic it_wr, output bit counts);
		int unsigned pick;
		pick   = $urandom_range(99, 0);
		it_wr  = 1'($urandom_range(1, 0));
		it_op  = dde_pkg::OpButton;
		it_btn = PressNone;
		if (pick < 68) begin
			it_btn = 8'd1 << $urandom_range(dde_pkg::BtnSend, dde_pkg::BtnUp);
		end else if (pick < 78) begin
			it_op = dde_pkg::OpValidate;
			it_wr = CheckWrite;
		end else if (pick < 86) begin
			it_op = dde_pkg::OpValidate;
			it_wr = CheckRead;
		end else begin
			it_op  = 1'($urandom_range(1, 0));
			it_btn = 8'($urandom_range(255, 0));
		end
		counts = (it_op == dde_pkg::OpValidate) ||
			(ones_in(it_btn) == 1 && it_btn <= PressSend);
	endtask

	task automatic run_random(input int unsigned goal, input int unsigned hold_every);
		logic                        it_op;
		logic [dde_pkg::ButtonW-1:0] it_btn;
		logic                        it_wr;
		bit                          counts;
		int unsigned                 done;
		done = 0;
		while (done < goal) begin
			draw_item(it_op, it_btn, it_wr, counts);
			send_item(it_op, it_btn, it_wr);
			if (counts) begin
				done++;
				if (hold_every != 0 && done % hold_every == 0)
					settle_panel();
			end
		end
	endtask

	// Presses in the reset mode: ignored patterns, digit wrap, cursor wrap and the send toggle.
	task automatic test_button_basics();
		send_item(dde_pkg::OpValidate, PressNone, CheckRead);
		send_item(dde_pkg::OpButton, PressNone, CheckRead);
		send_item(dde_pkg::OpButton, PressAll, CheckWrite);
		for (int b = dde_pkg::BtnSend + 1; b < dde_pkg::ButtonW; b++)
			send_item(dde_pkg::OpButton, 8'd1 << b, CheckRead);
		send_item(dde_pkg::OpButton, PressUp | PressDown, CheckRead);
		send_item(dde_pkg::OpButton, PressUp, CheckWrite);
		send_item(dde_pkg::OpButton, PressDown, CheckRead);
		send_item(dde_pkg::OpButton, PressDown, CheckRead);
		send_item(dde_pkg::OpButton, PressUp, CheckRead);
		send_item(dde_pkg::OpButton, PressLeft, CheckRead);
		send_item(dde_pkg::OpButton, PressRight, CheckRead);
		send_item(dde_pkg::OpButton, PressRight, CheckRead);
		send_item(dde_pkg::OpButton, PressLeft, CheckRead);
		send_item(dde_pkg::OpButton, PressSend, CheckRead);
		send_item(dde_pkg::OpButton, PressSend, CheckRead);
	endtask

	// Invalid mode rejection, a units-only span, a clamp to the limit and no clamp in open mode.
	task automatic test_mode_limits();
		load_mode(dde_pkg::ModeBad15);
		send_item(dde_pkg::OpValidate, PressAll, CheckRead);
		send_item(dde_pkg::OpValidate, PressNone, CheckWrite);
		load_mode(dde_pkg::ModeUnitsA);
		send_item(dde_pkg::OpButton, PressUp, CheckRead);
		send_item(dde_pkg::OpButton, PressUp, CheckRead);
		send_item(dde_pkg::OpButton, PressRight, CheckRead);
		send_item(dde_pkg::OpButton, PressLeft, CheckRead);
		send_item(dde_pkg::OpValidate, PressNone, CheckWrite);
		load_mode(dde_pkg::ModeOpen);
		send_item(dde_pkg::OpValidate, PressNone, CheckWrite);
	endtask

	// Every mode value in turn, with the sender holding off now and then
	// until the panel has drained.
	task automatic test_mode_sweep();
		for (int m = 0; m < ModeCount; m++) begin
			load_mode(4'(m));
			run_random(50, 40);
		end
	endtask

	// Neither side idles here, so transactions go back to back.
	task automatic test_back_to_back();
		no_idle = 1'b1;
		load_mode(dde_pkg::ModeOpen);
		run_random(80, 0);
		load_mode(4'($urandom_range(ModeCount - 1, 0)));
		run_random(50, 0);
		settle_panel();
		no_idle = 1'b0;
	endtask

	// The receiver draws a stall length before each result it takes.
	initial begin : drive_result_stall
		int unsigned hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(IdleMax, 0);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Every result taken is compared field by field with the oldest expectation.
	task automatic note_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= ReportMax)
				$display("mismatch on %s at %0t: expected %0d, got %0d",
					name, $realtime, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		panel_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_panels.size() == 0) begin
				fail_count++;
				if (fail_count <= ReportMax)
					$display("result at %0t with no transaction pending", $realtime);
			end else begin
				want = pending_panels.pop_front();
				note_field("digit_ten_thousands", 8'(want.digits[0]), 8'(digit_ten_thousands));
				note_field("digit_thousands", 8'(want.digits[1]), 8'(digit_thousands));
				note_field("digit_hundreds", 8'(want.digits[2]), 8'(digit_hundreds));
				note_field("digit_tens", 8'(want.digits[3]), 8'(digit_tens));
				note_field("digit_units", 8'(want.digits[4]), 8'(digit_units));
				note_field("cursor_pos", 8'(want.cursor), 8'(cursor_pos));
				note_field("sending", 8'(want.sending), 8'(sending));
				note_field("mode_ok", 8'(want.ok), 8'(mode_ok));
			end
		end
	end

	// The run is abandoned when no channel has moved a transaction for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		digit_mode  <= dde_pkg::ModeReset;
		in_valid    <= 1'b0;
		op          <= dde_pkg::OpButton;
		buttons     <= PressNone;
		write_check <= CheckRead;
		pd_mode     = dde_pkg::ModeReset;
		pd_digits   = '0;
		pd_cursor   = dde_pkg::CursorLast;
		pd_sending  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_button_basics();
		test_mode_limits();
		test_mode_sweep();
		test_back_to_back();

		settle_panel();
		release_cfg();
		// Give a stray extra result time to show up.
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
